// ===== src/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

    // fixed point format of coordinates and of the line parameter
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_SHIFT = 30;

    // datapath widths
    localparam int W_COORD = 32;
    localparam int W_DIFF  = W_COORD + 1;
    localparam int W_PROD  = 2 * W_DIFF;
    localparam int W_SUM   = W_PROD + 1;
    localparam int W_MAG   = W_SUM - 2;
    localparam int W_ROOT  = (W_MAG + 2 * ROOT_SHIFT + 1) / 2;
    localparam int W_ACC   = 128;
    localparam int W_Q     = 64;
    localparam int W_DE    = W_ROOT - ROOT_SHIFT;

    // iteration counts
    localparam int SQ_STEPS   = W_ROOT;
    localparam int DIV_STAGES = W_Q + 1;
    localparam int T_BITS     = W_COORD - 1;
    localparam int PERP_BITS  = W_DE + 2;
    localparam int P_BITS     = W_Q;
    localparam int COS_FRAC   = 16;
    localparam int COS_BITS   = COS_FRAC + 1;
    localparam int COS_STAGES = COS_BITS + 1;
    localparam int W_SAT      = PERP_BITS;

    localparam logic [COS_BITS-1:0] COS_ONE = COS_BITS'(1) << COS_FRAC;
    localparam logic [W_COORD-1:0]  POS_MAX = {1'b0, {(W_COORD-1){1'b1}}};
    localparam logic [W_COORD-1:0]  NEG_MAX = {1'b1, {(W_COORD-1){1'b0}}};

    // register indexes
    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [W_COORD-1:0] query_x;
        logic signed [W_COORD-1:0] query_y;
    } t_query;

    typedef struct packed {
        logic signed [W_COORD-1:0] signed_distance;
        logic [COS_BITS-1:0]       endpoint_cosine;
        logic [W_COORD-2:0]        clamped_distance;
        logic signed [W_COORD-1:0] line_parameter;
        logic                      degenerate;
    } t_result;

    typedef struct packed {
        logic signed [W_COORD-1:0] start_x;
        logic signed [W_COORD-1:0] start_y;
        logic signed [W_COORD-1:0] end_x;
        logic signed [W_COORD-1:0] end_y;
    } t_seg;

    typedef struct packed {
        logic dt_neg;
        logic cr_neg;
        logic deg;
        logic inseg;
        logic strict;
        logic q2_zero;
    } t_flags;

    typedef struct packed {
        logic [W_MAG-1:0] l2;
        logic [W_MAG-1:0] dt_abs;
        logic [W_MAG-1:0] cr_abs;
        logic [W_MAG-1:0] d_abs;
        t_flags           flags;
    } t_carry;

    typedef struct packed {
        t_carry           carry;
        logic [W_MAG-1:0] q2;
    } t_front;

    typedef struct packed {
        t_carry            carry;
        logic [W_ROOT-1:0] root_n;
        logic [W_ROOT-1:0] root_m;
    } t_mid;

    typedef struct packed {
        logic [T_BITS-1:0]    t_q;
        logic                 t_sat;
        logic [PERP_BITS-1:0] perp;
        logic                 perp_sat;
        logic [P_BITS-1:0]    p_q;
        logic [W_ROOT-1:0]    root_m;
        t_flags               flags;
    } t_back;

    // state of one digit-by-digit square root
    typedef struct packed {
        logic [W_ACC-1:0] x;
        logic [W_ACC-1:0] res;
    } t_sq;

    // state of one restoring division
    typedef struct packed {
        logic [W_ACC-1:0] rem;
        logic [W_Q-1:0]   q;
    } t_div;

    // one root digit, weight 4^k
    function automatic t_sq sqrt_step(input t_sq s, input int unsigned k);
        logic [W_ACC-1:0] bitv;
        logic [W_ACC-1:0] trial;
        t_sq              r;
        bitv  = W_ACC'(1) << (2 * k);
        trial = s.res + bitv;
        r     = s;
        if (s.x >= trial) begin
            r.x   = s.x - trial;
            r.res = (s.res >> 1) + bitv;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    // one quotient bit, weight 2^k
    function automatic t_div div_step(input t_div s, input logic [W_ACC-1:0] d,
                                      input int unsigned k);
        logic [W_ACC-1:0] dk;
        t_div             r;
        dk = d << k;
        r  = s;
        if (s.rem >= dk) begin
            r.rem = s.rem - dk;
            r.q   = s.q | (W_Q'(1) << k);
        end
        return r;
    endfunction

    // signed 32-bit pattern of a magnitude and sign, saturated
    function automatic logic [W_COORD-1:0] sat_s32(input logic neg, input logic big,
                                                   input logic [W_SAT-1:0] mag);
        logic [W_COORD-1:0] r;
        if (!neg) begin
            if (big || mag > W_SAT'(POS_MAX)) r = POS_MAX;
            else r = mag[W_COORD-1:0];
        end else begin
            if (big || mag >= W_SAT'(NEG_MAX)) r = NEG_MAX;
            else r = W_COORD'(0) - mag[W_COORD-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/segment_signed_distance.sv =====
`timescale 1ns / 1ps
// throughput: one request per cycle while o_stall is low; the front products, the root digit stages and the
// divider bit stages are each a pipeline stage of their own, so nothing iterates in place
// a stalled result holds the pipeline only once the last stage is occupied
// reset: synchronous, active low; clears valid bits, loads the segment (0,0)-(1,0)

module segment_signed_distance import ssd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_query             i_query,
    output logic               o_valid,
    input  logic               i_stall,
    output t_result            o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [W_COORD-1:0] i_cfg_data
);

    t_seg    r_seg;
    logic    r_out_valid;
    t_result r_out;
    logic    w_en, w_out_load;
    logic    w_f_valid, w_r_valid, w_q_valid, w_b_valid;
    t_front  w_f_data;
    t_mid    w_r_data;
    t_back   w_q_data;
    t_result w_b_data;

    // segment registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.start_x <= '0;
            r_seg.start_y <= '0;
            r_seg.end_x   <= W_COORD'(1) << FRAC_BITS;
            r_seg.end_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_X: r_seg.start_x <= i_cfg_data;
                CFG_START_Y: r_seg.start_y <= i_cfg_data;
                CFG_END_X:   r_seg.end_x   <= i_cfg_data;
                CFG_END_Y:   r_seg.end_y   <= i_cfg_data;
            endcase
        end
    end

    // pipeline moves unless a finished result is blocked behind the output
    assign w_out_load = !r_out_valid || !i_stall;
    assign w_en       = w_out_load || !w_b_valid;
    assign o_stall    = !w_en;

    ssd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_query (i_query),
        .i_seg   (r_seg),
        .o_valid (w_f_valid),
        .o_data  (w_f_data)
    );

    ssd_roots u_roots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_data  (w_f_data),
        .o_valid (w_r_valid),
        .o_data  (w_r_data)
    );

    ssd_quot u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_r_valid),
        .i_data  (w_r_data),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    ssd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_q_valid),
        .i_data  (w_q_data),
        .o_valid (w_b_valid),
        .o_data  (w_b_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_b_data;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.degenerate |->
            o_result.signed_distance == '0 && o_result.endpoint_cosine == '0
            && o_result.clamped_distance == '0 && o_result.line_parameter == '0)
        else $error("degenerate result with nonzero fields");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.endpoint_cosine <= COS_ONE)
        else $error("endpoint cosine above one");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && w_b_valid |=> o_valid)
        else $error("result dropped under stall");
`endif

endmodule

// ===== src/ssd_front.sv =====
`timescale 1ns / 1ps

module ssd_front import ssd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_query i_query,
    input  t_seg   i_seg,
    output logic   o_valid,
    output t_front o_data
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] r_vld;

    logic signed [W_DIFF-1:0]  r1_abx, r1_aby, r1_aqx, r1_aqy;
    logic signed [W_COORD-1:0] r1_qx, r1_qy;

    logic signed [W_PROD-1:0]  r2_xx, r2_yy, r2_dx, r2_dy, r2_cx, r2_cy;
    logic signed [W_DIFF-1:0]  r2_abx, r2_aby;
    logic signed [W_COORD-1:0] r2_qx, r2_qy;

    logic signed [W_SUM-1:0]   r3_l2, r3_dt, r3_cr;
    logic signed [W_DIFF-1:0]  r3_abx, r3_aby;
    logic signed [W_COORD-1:0] r3_qx, r3_qy;

    logic signed [W_SUM-1:0]   r4_l2, r4_dt, r4_cr;
    logic signed [W_DIFF-1:0]  r4_abx, r4_aby, r4_ex, r4_ey;

    logic signed [W_PROD-1:0]  r5_ex2, r5_ey2, r5_dex, r5_dey;
    logic [W_MAG-1:0]          r5_l2, r5_dt_abs, r5_cr_abs;
    t_flags                    r5_flags;

    logic signed [W_SUM-1:0]   r6_q2, r6_d;
    logic [W_MAG-1:0]          r6_l2, r6_dt_abs, r6_cr_abs;
    t_flags                    r6_flags;

    t_front                    r7;

    logic                      w_far;
    logic signed [W_SUM-1:0]   w_dt_mag, w_cr_mag, w_d_mag;
    logic                      w_dt_neg;
    t_flags                    w_flags;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // segment and query vectors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_abx <= W_DIFF'(i_seg.end_x) - W_DIFF'(i_seg.start_x);
            r1_aby <= W_DIFF'(i_seg.end_y) - W_DIFF'(i_seg.start_y);
            r1_aqx <= W_DIFF'(i_query.query_x) - W_DIFF'(i_seg.start_x);
            r1_aqy <= W_DIFF'(i_query.query_y) - W_DIFF'(i_seg.start_y);
            r1_qx  <= i_query.query_x;
            r1_qy  <= i_query.query_y;
        end
    end

    // products for length, dot and cross
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_xx  <= r1_abx * r1_abx;
            r2_yy  <= r1_aby * r1_aby;
            r2_dx  <= r1_aqx * r1_abx;
            r2_dy  <= r1_aqy * r1_aby;
            r2_cx  <= r1_aby * r1_aqx;
            r2_cy  <= r1_abx * r1_aqy;
            r2_abx <= r1_abx;
            r2_aby <= r1_aby;
            r2_qx  <= r1_qx;
            r2_qy  <= r1_qy;
        end
    end

    // sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_l2  <= W_SUM'(r2_xx) + W_SUM'(r2_yy);
            r3_dt  <= W_SUM'(r2_dx) + W_SUM'(r2_dy);
            r3_cr  <= W_SUM'(r2_cx) - W_SUM'(r2_cy);
            r3_abx <= r2_abx;
            r3_aby <= r2_aby;
            r3_qx  <= r2_qx;
            r3_qy  <= r2_qy;
        end
    end

    // nearer endpoint: the far one when twice the dot exceeds the squared length
    assign w_far = !r3_dt[W_SUM-1] && ((r3_dt <<< 1) > r3_l2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ex  <= (w_far ? W_DIFF'(i_seg.end_x) : W_DIFF'(i_seg.start_x)) - W_DIFF'(r3_qx);
            r4_ey  <= (w_far ? W_DIFF'(i_seg.end_y) : W_DIFF'(i_seg.start_y)) - W_DIFF'(r3_qy);
            r4_l2  <= r3_l2;
            r4_dt  <= r3_dt;
            r4_cr  <= r3_cr;
            r4_abx <= r3_abx;
            r4_aby <= r3_aby;
        end
    end

    // magnitudes and branch flags
    assign w_dt_neg = r4_dt[W_SUM-1];
    assign w_dt_mag = w_dt_neg ? -r4_dt : r4_dt;
    assign w_cr_mag = r4_cr[W_SUM-1] ? -r4_cr : r4_cr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ex2    <= r4_ex * r4_ex;
            r5_ey2    <= r4_ey * r4_ey;
            r5_dex    <= r4_abx * r4_ex;
            r5_dey    <= r4_aby * r4_ey;
            r5_l2     <= r4_l2[W_MAG-1:0];
            r5_dt_abs <= w_dt_mag[W_MAG-1:0];
            r5_cr_abs <= w_cr_mag[W_MAG-1:0];
            r5_flags  <= '{
                dt_neg:  w_dt_neg,
                cr_neg:  r4_cr[W_SUM-1],
                deg:     (r4_l2 == '0),
                inseg:   !w_dt_neg && (w_dt_mag[W_MAG-1:0] <= r4_l2[W_MAG-1:0]),
                strict:  !w_dt_neg && (w_dt_mag != '0)
                         && (w_dt_mag[W_MAG-1:0] < r4_l2[W_MAG-1:0]),
                q2_zero: 1'b0
            };
        end
    end

    // endpoint distance squared and endpoint dot
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_q2     <= W_SUM'(r5_ex2) + W_SUM'(r5_ey2);
            r6_d      <= W_SUM'(r5_dex) + W_SUM'(r5_dey);
            r6_l2     <= r5_l2;
            r6_dt_abs <= r5_dt_abs;
            r6_cr_abs <= r5_cr_abs;
            r6_flags  <= r5_flags;
        end
    end

    assign w_d_mag = r6_d[W_SUM-1] ? -r6_d : r6_d;

    // flags with the query-on-endpoint bit filled in
    always_comb begin
        w_flags         = r6_flags;
        w_flags.q2_zero = (r6_q2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7.q2                    <= r6_q2[W_MAG-1:0];
            r7.carry.l2              <= r6_l2;
            r7.carry.dt_abs          <= r6_dt_abs;
            r7.carry.cr_abs          <= r6_cr_abs;
            r7.carry.d_abs           <= w_d_mag[W_MAG-1:0];
            r7.carry.flags           <= w_flags;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_data  = r7;

endmodule

// ===== src/ssd_roots.sv =====
`timescale 1ns / 1ps

module ssd_roots import ssd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_front i_data,
    output logic   o_valid,
    output t_mid   o_data
);

    logic [SQ_STEPS-1:0] r_vld;
    t_sq                 r_n [SQ_STEPS];
    t_sq                 r_m [SQ_STEPS];
    t_carry              r_c [SQ_STEPS];
    t_sq                 w_n_init;
    t_sq                 w_m_init;

    // scaled radicands of the segment length and the endpoint distance
    assign w_n_init = '{x: W_ACC'(i_data.carry.l2) << (2 * ROOT_SHIFT), res: '0};
    assign w_m_init = '{x: W_ACC'(i_data.q2) << (2 * ROOT_SHIFT), res: '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STEPS-2:0], i_valid};
        end
    end

    // one root digit of each square root per stage, top digit first
    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[s] <= sqrt_step(w_n_init, SQ_STEPS - 1);
                    r_m[s] <= sqrt_step(w_m_init, SQ_STEPS - 1);
                    r_c[s] <= i_data.carry;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[s] <= sqrt_step(r_n[s-1], SQ_STEPS - 1 - s);
                    r_m[s] <= sqrt_step(r_m[s-1], SQ_STEPS - 1 - s);
                    r_c[s] <= r_c[s-1];
                end
            end
        end
    end

    assign o_valid       = r_vld[SQ_STEPS-1];
    assign o_data.carry  = r_c[SQ_STEPS-1];
    assign o_data.root_n = r_n[SQ_STEPS-1].res[W_ROOT-1:0];
    assign o_data.root_m = r_m[SQ_STEPS-1].res[W_ROOT-1:0];

endmodule

// ===== src/ssd_quot.sv =====
`timescale 1ns / 1ps

module ssd_quot import ssd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_mid  i_data,
    output logic  o_valid,
    output t_back o_data
);

    typedef struct packed {
        logic [W_MAG-1:0]  l2;
        logic [W_ROOT-1:0] root_n;
        logic [W_ROOT-1:0] root_m;
        t_flags            flags;
        logic              t_sat;
        logic              perp_sat;
        logic              p_sat;
    } t_qc;

    logic [DIV_STAGES-1:0] r_vld;
    t_div                  r_t [DIV_STAGES];
    t_div                  r_pp [DIV_STAGES];
    t_div                  r_p [DIV_STAGES];
    t_qc                   r_c [DIV_STAGES];
    logic [W_ACC-1:0]      w_t_num, w_pp_num, w_p_num;
    logic [W_ACC-1:0]      w_l2, w_n;
    t_qc                   w_c0;

    // numerators and divisors
    assign w_l2     = W_ACC'(i_data.carry.l2);
    assign w_n      = W_ACC'(i_data.root_n);
    assign w_t_num  = W_ACC'(i_data.carry.dt_abs) << FRAC_BITS;
    assign w_pp_num = W_ACC'(i_data.carry.cr_abs) << ROOT_SHIFT;
    assign w_p_num  = W_ACC'(i_data.carry.d_abs) << (2 * ROOT_SHIFT);

    // overflow checks: the quotient would not fit its bit count
    assign w_c0 = '{
        l2:       i_data.carry.l2,
        root_n:   i_data.root_n,
        root_m:   i_data.root_m,
        flags:    i_data.carry.flags,
        t_sat:    (w_t_num >= (w_l2 << T_BITS)),
        perp_sat: (w_pp_num >= (w_n << PERP_BITS)),
        p_sat:    (w_p_num >= (w_n << P_BITS))
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    // first stage checks, each later stage settles one bit of every quotient that is that wide
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_t[s]  <= '{rem: w_t_num, q: '0};
                    r_pp[s] <= '{rem: w_pp_num, q: '0};
                    r_p[s]  <= '{rem: w_p_num, q: '0};
                    r_c[s]  <= w_c0;
                end
            end
        end else begin : g_rest
            localparam int K = DIV_STAGES - 1 - s;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_t[s]  <= (K < T_BITS)
                        ? div_step(r_t[s-1], W_ACC'(r_c[s-1].l2), K) : r_t[s-1];
                    r_pp[s] <= (K < PERP_BITS)
                        ? div_step(r_pp[s-1], W_ACC'(r_c[s-1].root_n), K) : r_pp[s-1];
                    r_p[s]  <= div_step(r_p[s-1], W_ACC'(r_c[s-1].root_n), K);
                    r_c[s]  <= r_c[s-1];
                end
            end
        end
    end

    assign o_valid         = r_vld[DIV_STAGES-1];
    assign o_data.t_q      = r_t[DIV_STAGES-1].q[T_BITS-1:0];
    assign o_data.t_sat    = r_c[DIV_STAGES-1].t_sat;
    assign o_data.perp     = r_pp[DIV_STAGES-1].q[PERP_BITS-1:0];
    assign o_data.perp_sat = r_c[DIV_STAGES-1].perp_sat;
    assign o_data.p_q      = r_c[DIV_STAGES-1].p_sat ? '1 : r_p[DIV_STAGES-1].q;
    assign o_data.root_m   = r_c[DIV_STAGES-1].root_m;
    assign o_data.flags    = r_c[DIV_STAGES-1].flags;

endmodule

// ===== src/ssd_back.sv =====
`timescale 1ns / 1ps

module ssd_back import ssd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_back   i_data,
    output logic    o_valid,
    output t_result o_data
);

    typedef struct packed {
        t_back b;
        logic  c_sat;
    } t_bc;

    logic [COS_STAGES:0]    r_vld;
    t_div                   r_cd [COS_STAGES];
    t_bc                    r_c [COS_STAGES];
    t_result                r_out;
    logic [W_ACC-1:0]       w_num;
    t_back                  w_b;
    logic [COS_BITS-1:0]    w_cq;
    logic [W_DE-1:0]        w_de;
    logic                   w_onseg;
    logic [W_SAT-1:0]       w_clamp_mag;
    logic                   w_clamp_big;
    logic [COS_BITS-1:0]    w_cos;
    t_result                n_out;

    assign w_num = W_ACC'(i_data.p_q) << COS_FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[COS_STAGES-1:0], i_valid};
        end
    end

    // cosine quotient, one bit per stage after the first
    for (genvar s = 0; s < COS_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_cd[s] <= '{rem: w_num, q: '0};
                    r_c[s]  <= '{b: i_data,
                                 c_sat: (w_num >= (W_ACC'(i_data.root_m) << COS_BITS))};
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_cd[s] <= div_step(r_cd[s-1], W_ACC'(r_c[s-1].b.root_m),
                                        COS_STAGES - 1 - s);
                    r_c[s]  <= r_c[s-1];
                end
            end
        end
    end

    // result selection and saturation
    assign w_b         = r_c[COS_STAGES-1].b;
    assign w_cq        = r_cd[COS_STAGES-1].q[COS_BITS-1:0];
    assign w_de        = w_b.root_m[W_ROOT-1:ROOT_SHIFT];
    assign w_onseg     = w_b.flags.inseg && !w_b.perp_sat && (w_b.perp <= W_SAT'(w_de));
    assign w_clamp_mag = w_b.flags.strict ? w_b.perp : W_SAT'(w_de);
    assign w_clamp_big = (w_b.flags.strict && w_b.perp_sat)
                         || (w_clamp_mag > W_SAT'(POS_MAX));

    always_comb begin
        if (w_onseg || w_b.flags.q2_zero) begin
            w_cos = '0;
        end else if (r_c[COS_STAGES-1].c_sat || (w_cq > COS_ONE)) begin
            w_cos = COS_ONE;
        end else begin
            w_cos = w_cq;
        end
    end

    always_comb begin
        if (w_b.flags.deg) begin
            n_out            = '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.signed_distance  = sat_s32(w_b.flags.cr_neg, 1'b0,
                                             w_onseg ? w_b.perp : W_SAT'(w_de));
            n_out.endpoint_cosine  = w_cos;
            n_out.clamped_distance = w_clamp_big ? POS_MAX[W_COORD-2:0]
                                                 : w_clamp_mag[W_COORD-2:0];
            n_out.line_parameter   = sat_s32(w_b.flags.dt_neg, w_b.t_sat, W_SAT'(w_b.t_q));
            n_out.degenerate       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[COS_STAGES];
    assign o_data  = r_out;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ssd_pkg::*;

    localparam int LATENCY     = 155;
    localparam int CYCLE_LIMIT = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_query             i_query;
    logic               o_valid;
    logic               i_stall;
    t_result            o_result;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [W_COORD-1:0] i_cfg_data;

    segment_signed_distance u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_query    (i_query),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // segment copy held by the predictor
    logic signed [31:0] seg_ax, seg_ay, seg_bx, seg_by;

    t_result     pending_results[$];
    int          mismatch_count;
    int          cycle_count;
    logic        steady_phase;

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // floor square root
    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [63:0]  root;
        logic [63:0]  trial;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if ({64'd0, trial} * {64'd0, trial} <= x) root = trial;
        end
        return root;
    endfunction

    function automatic logic [127:0] magnitude(input logic signed [127:0] v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [31:0] saturate32(input logic neg, input logic [127:0] mag);
        if (!neg) return (mag > 128'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        return (mag >= 128'h80000000) ? 32'h80000000 : 32'd0 - mag[31:0];
    endfunction

    // distance, parameter and cosine for one query point
    function automatic t_result predict_distance(input t_query q);
        logic signed [127:0] ax, ay, bx, by, qx, qy;
        logic signed [127:0] abx, aby, aqx, aqy, ex, ey, l2, dt, cr, dd;
        logic [127:0]        q2, tq, nab, perp, de, pq, m, c, mag;
        logic                far, inseg, strict;
        t_result             r;
        ax = seg_ax; ay = seg_ay; bx = seg_bx; by = seg_by;
        qx = q.query_x; qy = q.query_y;
        r = '0;
        abx = bx - ax; aby = by - ay;
        aqx = qx - ax; aqy = qy - ay;
        l2 = abx * abx + aby * aby;
        if (l2 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        dt = aqx * abx + aqy * aby;
        cr = aby * aqx - abx * aqy;
        tq = (magnitude(dt) << FRAC_BITS) / 128'(l2);
        r.line_parameter = saturate32(dt < 0, tq);
        far    = dt >= 0 && (dt <<< 1) > l2;
        inseg  = dt >= 0 && dt <= l2;
        strict = dt > 0 && dt < l2;
        ex = (far ? bx : ax) - qx;
        ey = (far ? by : ay) - qy;
        q2 = 128'(ex * ex + ey * ey);
        de = {64'd0, floor_sqrt(q2)};
        nab = {64'd0, floor_sqrt(128'(l2) << 60)};
        perp = (magnitude(cr) << 30) / nab;
        mag = strict ? perp : de;
        r.clamped_distance = (mag > 128'h7FFFFFFF) ? 31'h7FFFFFFF : mag[30:0];
        if (inseg && perp <= de) begin
            r.signed_distance = saturate32(cr < 0, perp);
        end else begin
            r.signed_distance = saturate32(cr < 0, de);
            if (q2 != 0) begin
                dd = abx * ex + aby * ey;
                pq = (magnitude(dd) << 60) / nab;
                m  = {64'd0, floor_sqrt(q2 << 60)};
                c  = (pq << 16) / m;
                r.endpoint_cosine = (c > 128'd65536) ? 17'h10000 : c[16:0];
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_result);
            end else begin
                want = pending_results.pop_front();
                if (want.signed_distance !== o_result.signed_distance
                    || want.endpoint_cosine !== o_result.endpoint_cosine
                    || want.clamped_distance !== o_result.clamped_distance
                    || want.line_parameter !== o_result.line_parameter
                    || want.degenerate !== o_result.degenerate) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected sd=%h cos=%h cd=%h t=%h deg=%b, got sd=%h cos=%h cd=%h t=%h deg=%b",
                                 want.signed_distance, want.endpoint_cosine,
                                 want.clamped_distance, want.line_parameter, want.degenerate,
                                 o_result.signed_distance, o_result.endpoint_cosine,
                                 o_result.clamped_distance, o_result.line_parameter,
                                 o_result.degenerate);
                end
            end
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        i_stall <= !steady_phase && ($urandom_range(99) < 24);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // send one request, holding it until accepted
    task automatic send_query(input logic [31:0] qx, input logic [31:0] qy);
        t_query q;
        q.query_x = qx;
        q.query_y = qy;
        if (!steady_phase) begin
            while ($urandom_range(99) < 24) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_query <= q;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_distance(q));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    // segment register write, only with the pipeline empty
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_X: seg_ax = value;
            CFG_START_Y: seg_ay = value;
            CFG_END_X:   seg_bx = value;
            default:     seg_by = value;
        endcase
    endtask

    task automatic set_segment(input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] bx, input logic [31:0] by);
        write_reg(CFG_START_X, ax);
        write_reg(CFG_START_Y, ay);
        write_reg(CFG_END_X, bx);
        write_reg(CFG_END_Y, by);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
        endcase
    endfunction

    // points on, beside and beyond the reset segment (0,0)-(1,0)
    task automatic test_reset_segment;
        send_query(32'h00008000, 32'h00010000);
        send_query(32'h00008000, 32'hFFFF0000);
        send_query(32'h00008000, 32'h00000000);
        send_query(32'h00000000, 32'h00000000);
        send_query(32'h00010000, 32'h00000000);
        send_query(32'hFFFE0000, 32'h00010000);
        send_query(32'h00030000, 32'hFFFF0000);
        send_query(32'h00020000, 32'h00000000);
        send_query(32'h80000000, 32'h80000000);
        send_query(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_query(32'h80000000, 32'h7FFFFFFF);
        send_query(32'h7FFFFFFF, 32'h80000000);
        send_query(32'h00008000, 32'h00000100);
    endtask

    // zero-length segment
    task automatic test_degenerate;
        set_segment(32'h00050000, 32'hFFFD0000, 32'h00050000, 32'hFFFD0000);
        send_query(32'h00050000, 32'hFFFD0000);
        send_query(32'h80000000, 32'h7FFFFFFF);
        send_query(32'h12345678, 32'h9ABCDEF0);
    endtask

    // segment spanning the full coordinate range
    task automatic test_extreme_segment;
        set_segment(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_query(32'h80000000, 32'h7FFFFFFF);
        send_query(32'h7FFFFFFF, 32'h80000000);
        send_query(32'h00000000, 32'h00000000);
        send_query(32'h80000000, 32'h80000000);
        send_query(32'h7FFFFFFF, 32'h7FFFFFFF);
        set_segment(32'h7FFFFFFF, 32'h00000000, 32'h80000000, 32'h00000000);
        send_query(32'h00000000, 32'h80000000);
        send_query(32'h7FFFFFFF, 32'h7FFFFFFF);
    endtask

    // random segments with random queries
    task automatic test_random_queries;
        for (int phase = 0; phase < 10; phase++) begin
            set_segment(rand_word(), rand_word(), rand_word(), rand_word());
            steady_phase = (phase == 4);
            for (int n = 0; n < 85; n++) begin
                if ($urandom_range(3) == 0)
                    send_query(seg_ax + 32'($signed($urandom_range(2048)) - 1024),
                               seg_ay + 32'($signed($urandom_range(2048)) - 1024));
                else
                    send_query(rand_word(), rand_word());
            end
            steady_phase = 1'b0;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_query      = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        steady_phase = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        seg_ax = 32'd0; seg_ay = 32'd0; seg_bx = 32'd65536; seg_by = 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_segment();
        test_degenerate();
        test_extreme_segment();
        test_random_queries();
        drain();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ssd_pkg.sv
src/ssd_front.sv
src/ssd_roots.sv
src/ssd_quot.sv
src/ssd_back.sv
src/segment_signed_distance.sv
tb/tb_top.sv
